@@ rtl/hrtc_pkg.sv @@
package hrtc_pkg;

  localparam int TempW    = 12;
  localparam int BandW    = 8;
  localparam int AgeW     = 8;
  localparam int BattW    = 7;
  localparam int CmdW     = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic [BattW-1:0]        batt_t;
  typedef logic [AgeW-1:0]         age_t;
  typedef logic [CmdW-1:0]         cmd_code_t;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE      = 3'd0,
    CMD_FORCE_ON  = 3'd1,
    CMD_FORCE_OFF = 3'd2,
    CMD_PROG_ON   = 3'd3,
    CMD_PROG_OFF  = 3'd4
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_HYST_BAND     = 3'd1,
    REG_SIG_TIMEOUT   = 3'd2,
    REG_BATT_LOW      = 3'd3,
    REG_BATT_CRITICAL = 3'd4
  } reg_idx_t;

  localparam temp_t              SetpointReset = 12'sd304;
  localparam logic [BandW-1:0]   HystReset     = 8'd16;
  localparam age_t               TimeoutReset  = 8'd30;
  localparam batt_t              BattLowReset  = 7'd20;
  localparam batt_t              BattCritReset = 7'd10;
  localparam temp_t              TempReset     = 12'sd533;
  localparam batt_t              BattReset     = 7'd101;
  localparam age_t               AgeMax        = 8'd255;

endpackage

@@ rtl/hrtc_ifs.sv @@
interface hrtc_in_if;
  import hrtc_pkg::*;

  logic      valid;
  logic      ready;
  cmd_code_t cmd;
  logic      mains_present;
  logic      minute_tick;
  logic      report_valid;
  temp_t     report_temp;
  batt_t     report_battery;

  modport source (
    output valid, cmd, mains_present, minute_tick, report_valid, report_temp,
           report_battery,
    input  ready
  );

  modport sink (
    input  valid, cmd, mains_present, minute_tick, report_valid, report_temp,
           report_battery,
    output ready
  );
endinterface

interface hrtc_out_if;
  import hrtc_pkg::*;

  logic  valid;
  logic  ready;
  logic  heating_on;
  logic  program_on;
  logic  forced_on;
  logic  command_refused;
  logic  alert_no_signal;
  logic  alert_battery_low;
  logic  alert_battery_critical;
  age_t  report_age_min;
  temp_t current_temp;

  modport source (
    output valid, heating_on, program_on, forced_on, command_refused,
           alert_no_signal, alert_battery_low, alert_battery_critical,
           report_age_min, current_temp,
    input  ready
  );

  modport sink (
    input  valid, heating_on, program_on, forced_on, command_refused,
           alert_no_signal, alert_battery_low, alert_battery_critical,
           report_age_min, current_temp,
    output ready
  );
endinterface

@@ rtl/heating_relay_thermostat_controller.sv @@
// An accepted beat passes the input register and then the result register to
// out_ch. Throughput: one beat per cycle unless out_ch.ready stalls; the two
// registers are separated by one pass of flag logic and two 14-bit compares.
// Reset: synchronous on rst_n low; clears handshake valids, control flags,
// alert latches and age, and loads the default registers and stored report.
module heating_relay_thermostat_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  hrtc_in_if.sink                      in_ch,
  hrtc_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [hrtc_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [hrtc_pkg::CfgDataW-1:0] cfg_wdata
);
  import hrtc_pkg::*;

  temp_t            setpoint_r;
  logic [BandW-1:0] band_r;
  age_t             timeout_r;
  batt_t            batt_low_r;
  batt_t            batt_crit_r;

  logic  heat_r, prog_r, forced_r, mprev_r;
  age_t  age_r;
  temp_t temp_r;
  batt_t batt_r;
  logic  latch_sig_r, latch_low_r, latch_crit_r;

  logic      s1_v_r;
  cmd_code_t s1_cmd_r;
  logic      s1_mains_r, s1_tick_r, s1_rvalid_r;
  temp_t     s1_rtemp_r;
  batt_t     s1_rbatt_r;

  logic  out_v_r;
  logic  o_heat_r, o_prog_r, o_forced_r, o_refused_r;
  logic  o_sig_r, o_low_r, o_crit_r;
  age_t  o_age_r;
  temp_t o_temp_r;

  logic  advance, in_take;
  logic  heat_nxt, prog_nxt, forced_nxt, mprev_nxt, refused_nxt;
  logic  sig_fire, low_fire, crit_fire;
  age_t  age_tick, age_nxt;
  temp_t temp_nxt;
  batt_t batt_nxt;
  logic signed [TempW+1:0] t2, s2, lo_lim, hi_lim, band_x;

  assign advance  = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || advance;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign t2     = {temp_r[TempW-1], temp_r, 1'b0};
  assign s2     = {setpoint_r[TempW-1], setpoint_r, 1'b0};
  assign band_x = $signed({{(TempW+2-BandW){1'b0}}, band_r});
  assign lo_lim = s2 - band_x;
  assign hi_lim = s2 + band_x;

  always_comb begin
    prog_nxt    = prog_r;
    forced_nxt  = forced_r;
    refused_nxt = 1'b0;
    case (s1_cmd_r)
      CMD_FORCE_ON, CMD_FORCE_OFF: begin
        if (prog_r) begin
          refused_nxt = 1'b1;
        end else begin
          forced_nxt = (s1_cmd_r == CMD_FORCE_ON);
        end
      end
      CMD_PROG_ON: begin
        prog_nxt = 1'b1;
      end
      CMD_PROG_OFF: begin
        prog_nxt   = 1'b0;
        forced_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    age_tick = (s1_tick_r && age_r != AgeMax) ? age_r + 8'd1 : age_r;

    sig_fire  = !latch_sig_r && (age_tick > timeout_r);
    low_fire  = !latch_low_r && (batt_r < batt_low_r);
    crit_fire = !latch_crit_r && (batt_r < batt_crit_r);
    if (sig_fire) begin
      prog_nxt = 1'b0;
    end

    heat_nxt  = heat_r;
    mprev_nxt = mprev_r;
    if (s1_mains_r && !mprev_r && heat_r) begin
      heat_nxt  = 1'b0;
      mprev_nxt = 1'b1;
    end else if (!s1_mains_r && !mprev_r && prog_nxt) begin
      if (t2 < lo_lim) begin
        heat_nxt = 1'b1;
      end
      if (t2 > hi_lim) begin
        heat_nxt = 1'b0;
      end
    end else if (!s1_mains_r && forced_nxt) begin
      heat_nxt = 1'b1;
    end
    if (!s1_mains_r) begin
      mprev_nxt = 1'b0;
    end
    if (!forced_nxt && !prog_nxt) begin
      heat_nxt = 1'b0;
    end

    age_nxt  = age_tick;
    temp_nxt = temp_r;
    batt_nxt = batt_r;
    if (s1_rvalid_r) begin
      age_nxt  = '0;
      temp_nxt = s1_rtemp_r;
      batt_nxt = s1_rbatt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= SetpointReset;
      band_r       <= HystReset;
      timeout_r    <= TimeoutReset;
      batt_low_r   <= BattLowReset;
      batt_crit_r  <= BattCritReset;
      heat_r       <= 1'b0;
      prog_r       <= 1'b0;
      forced_r     <= 1'b0;
      mprev_r      <= 1'b0;
      age_r        <= '0;
      temp_r       <= TempReset;
      batt_r       <= BattReset;
      latch_sig_r  <= 1'b0;
      latch_low_r  <= 1'b0;
      latch_crit_r <= 1'b0;
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SETPOINT:      setpoint_r  <= temp_t'(cfg_wdata[TempW-1:0]);
          REG_HYST_BAND:     band_r      <= cfg_wdata[BandW-1:0];
          REG_SIG_TIMEOUT:   timeout_r   <= cfg_wdata[AgeW-1:0];
          REG_BATT_LOW:      batt_low_r  <= cfg_wdata[BattW-1:0];
          REG_BATT_CRITICAL: batt_crit_r <= cfg_wdata[BattW-1:0];
          default: begin
          end
        endcase
      end
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r      <= 1'b1;
        heat_r       <= heat_nxt;
        prog_r       <= prog_nxt;
        forced_r     <= forced_nxt;
        mprev_r      <= mprev_nxt;
        age_r        <= age_nxt;
        temp_r       <= temp_nxt;
        batt_r       <= batt_nxt;
        latch_sig_r  <= latch_sig_r | sig_fire;
        latch_low_r  <= latch_low_r | low_fire;
        latch_crit_r <= latch_crit_r | crit_fire;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r    <= in_ch.cmd;
      s1_mains_r  <= in_ch.mains_present;
      s1_tick_r   <= in_ch.minute_tick;
      s1_rvalid_r <= in_ch.report_valid;
      s1_rtemp_r  <= in_ch.report_temp;
      s1_rbatt_r  <= in_ch.report_battery;
    end
    if (advance) begin
      o_heat_r    <= heat_nxt;
      o_prog_r    <= prog_nxt;
      o_forced_r  <= forced_nxt;
      o_refused_r <= refused_nxt;
      o_sig_r     <= sig_fire;
      o_low_r     <= low_fire;
      o_crit_r    <= crit_fire;
      o_age_r     <= age_nxt;
      o_temp_r    <= temp_nxt;
    end
  end

  assign out_ch.valid                  = out_v_r;
  assign out_ch.heating_on             = o_heat_r;
  assign out_ch.program_on             = o_prog_r;
  assign out_ch.forced_on              = o_forced_r;
  assign out_ch.command_refused        = o_refused_r;
  assign out_ch.alert_no_signal        = o_sig_r;
  assign out_ch.alert_battery_low      = o_low_r;
  assign out_ch.alert_battery_critical = o_crit_r;
  assign out_ch.report_age_min         = o_age_r;
  assign out_ch.current_temp           = o_temp_r;

endmodule

@@ rtl/hrtc_checker.sv @@
module hrtc_sva (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      heating_on,
  input logic                      program_on,
  input logic                      forced_on,
  input logic                      alert_no_signal,
  input logic                      alert_battery_critical,
  input logic [hrtc_pkg::AgeW-1:0] report_age_min
);
  import hrtc_pkg::*;

  logic beat;
  logic seen_sig_r, seen_crit_r;

  assign beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_sig_r  <= 1'b0;
      seen_crit_r <= 1'b0;
    end else if (beat) begin
      seen_sig_r  <= seen_sig_r | alert_no_signal;
      seen_crit_r <= seen_crit_r | alert_battery_critical;
    end
  end

  a_heat_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!heating_on || forced_on || program_on))
    else $error("heating on with neither forced nor program mode");

  a_timeout_drops_program: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && alert_no_signal |-> !program_on)
    else $error("signal timeout left program mode on");

  a_alerts_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    beat |-> !(alert_no_signal && seen_sig_r) && !(alert_battery_critical && seen_crit_r))
    else $error("alert pulse repeated");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(heating_on) &&
      $stable(report_age_min))
    else $error("stalled result beat changed");

endmodule

bind heating_relay_thermostat_controller hrtc_sva u_hrtc_sva (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_ch.valid),
  .out_ready              (out_ch.ready),
  .heating_on             (out_ch.heating_on),
  .program_on             (out_ch.program_on),
  .forced_on              (out_ch.forced_on),
  .alert_no_signal        (out_ch.alert_no_signal),
  .alert_battery_critical (out_ch.alert_battery_critical),
  .report_age_min         (out_ch.report_age_min)
);

@@ dv/hrtc_checker.sv @@
module hrtc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  hrtc_in_if                            in_ch,
  hrtc_out_if                           out_ch,
  input  logic                          cfg_we,
  input  logic [hrtc_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [hrtc_pkg::CfgDataW-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hrtc_pkg::*;

  typedef struct packed {
    logic  heating;
    logic  prog;
    logic  forced;
    logic  refused;
    logic  a_sig;
    logic  a_low;
    logic  a_crit;
    age_t  age;
    temp_t temp;
  } relay_status_t;

  relay_status_t relay_status_q[$];

  temp_t            sp_q;
  logic [BandW-1:0] band_q;
  age_t             timeout_q;
  batt_t            low_lvl_q;
  batt_t            crit_lvl_q;

  logic  heat_q, prog_q, forced_q, mains_prev_q;
  logic  sig_latch, low_latch, crit_latch;
  age_t  age_q;
  temp_t temp_q;
  batt_t batt_q;

  function automatic relay_status_t thermostat_pass(cmd_code_t cmd, logic mains, logic tick,
                                                    logic rv, temp_t rtemp, batt_t rbatt);
    relay_status_t r;
    int t2, s2, b;
    r = '0;
    case (cmd)
      CMD_FORCE_ON, CMD_FORCE_OFF: begin
        if (prog_q) r.refused = 1'b1;
        else forced_q = (cmd == CMD_FORCE_ON);
      end
      CMD_PROG_ON: prog_q = 1'b1;
      CMD_PROG_OFF: begin
        prog_q   = 1'b0;
        forced_q = 1'b0;
      end
      default: ;
    endcase

    if (tick && age_q != AgeMax) age_q = age_q + 1'b1;

    if (!sig_latch && age_q > timeout_q) begin
      prog_q    = 1'b0;
      sig_latch = 1'b1;
      r.a_sig   = 1'b1;
    end
    if (!low_latch && batt_q < low_lvl_q) begin
      low_latch = 1'b1;
      r.a_low   = 1'b1;
    end
    if (!crit_latch && batt_q < crit_lvl_q) begin
      crit_latch = 1'b1;
      r.a_crit   = 1'b1;
    end

    t2 = 2 * int'(temp_q);
    s2 = 2 * int'(sp_q);
    b  = int'(band_q);
    if (mains && !mains_prev_q && heat_q) begin
      heat_q       = 1'b0;
      mains_prev_q = 1'b1;
    end else if (!mains && !mains_prev_q && prog_q) begin
      if (t2 < s2 - b && !heat_q) heat_q = 1'b1;
      if (t2 > s2 + b && heat_q) heat_q = 1'b0;
    end else if (!mains && forced_q && !heat_q) begin
      heat_q = 1'b1;
    end
    if (!mains && mains_prev_q) mains_prev_q = 1'b0;
    if (!forced_q && !prog_q && heat_q) heat_q = 1'b0;

    if (rv) begin
      temp_q = rtemp;
      batt_q = rbatt;
      age_q  = '0;
    end

    r.heating = heat_q;
    r.prog    = prog_q;
    r.forced  = forced_q;
    r.age     = age_q;
    r.temp    = temp_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] exp_v,
                                      logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    relay_status_t exp_r;
    if (!rst_n) begin
      sp_q         = SetpointReset;
      band_q       = HystReset;
      timeout_q    = TimeoutReset;
      low_lvl_q    = BattLowReset;
      crit_lvl_q   = BattCritReset;
      heat_q       = 1'b0;
      prog_q       = 1'b0;
      forced_q     = 1'b0;
      mains_prev_q = 1'b0;
      sig_latch    = 1'b0;
      low_latch    = 1'b0;
      crit_latch   = 1'b0;
      age_q        = '0;
      temp_q       = TempReset;
      batt_q       = BattReset;
      relay_status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SETPOINT:      sp_q       = cfg_wdata[TempW-1:0];
          REG_HYST_BAND:     band_q     = cfg_wdata[BandW-1:0];
          REG_SIG_TIMEOUT:   timeout_q  = cfg_wdata[AgeW-1:0];
          REG_BATT_LOW:      low_lvl_q  = cfg_wdata[BattW-1:0];
          REG_BATT_CRITICAL: crit_lvl_q = cfg_wdata[BattW-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        if (relay_status_q.size() == 0) begin
          $error("result beat with no pending expectation");
          fail_count++;
        end else begin
          exp_r = relay_status_q.pop_front();
          check_field("heating_on", 32'(exp_r.heating), 32'(out_ch.heating_on));
          check_field("program_on", 32'(exp_r.prog), 32'(out_ch.program_on));
          check_field("forced_on", 32'(exp_r.forced), 32'(out_ch.forced_on));
          check_field("command_refused", 32'(exp_r.refused),
                      32'(out_ch.command_refused));
          check_field("alert_no_signal", 32'(exp_r.a_sig),
                      32'(out_ch.alert_no_signal));
          check_field("alert_battery_low", 32'(exp_r.a_low),
                      32'(out_ch.alert_battery_low));
          check_field("alert_battery_critical", 32'(exp_r.a_crit),
                      32'(out_ch.alert_battery_critical));
          check_field("report_age_min", 32'(exp_r.age), 32'(out_ch.report_age_min));
          check_field("current_temp", 32'($signed(exp_r.temp)),
                      32'(out_ch.current_temp));
        end
      end

      if (in_ch.valid && in_ch.ready)
        relay_status_q.push_back(thermostat_pass(in_ch.cmd, in_ch.mains_present,
                                                 in_ch.minute_tick, in_ch.report_valid,
                                                 in_ch.report_temp, in_ch.report_battery));
    end
    pending <= relay_status_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hrtc_pkg::*;

  localparam int        LongHold      = 150;
  localparam int        WatchLimit    = 2000;
  localparam int        TailCycles    = 8;
  localparam int        PhaseLen      = 150;
  localparam int        SilenceLen    = 260;
  localparam cmd_code_t CmdSpareFirst = cmd_code_t'(CMD_PROG_OFF + 1);
  localparam cmd_code_t CmdSpareLast  = '1;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  fail_count;
  int                  pending;

  hrtc_in_if  in_ch();
  hrtc_out_if out_ch();

  heating_relay_thermostat_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  hrtc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  bit               calm;
  bit               mains_now;
  int               hold_seq;
  int               hold_seen;
  int               idle_run;
  temp_t            sp_now;
  logic [BandW-1:0] band_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run > WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    hold_seen = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_pass(cmd_code_t cmd, bit mains, bit tick, bit rv, temp_t t, batt_t b);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= cmd;
    in_ch.mains_present  <= mains;
    in_ch.minute_tick    <= tick;
    in_ch.report_valid   <= rv;
    in_ch.report_temp    <= t;
    in_ch.report_battery <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic load_regs(temp_t sp, logic [BandW-1:0] band, age_t tmo, batt_t lo,
                           batt_t cr);
    logic [CfgDataW-1:0] noise;
    noise = CfgDataW'($urandom);
    sp_now   = sp;
    band_now = band;
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SETPOINT;
    cfg_wdata <= sp;
    @(posedge clk);
    cfg_idx   <= REG_HYST_BAND;
    cfg_wdata <= {noise[CfgDataW-1:BandW], band};
    @(posedge clk);
    cfg_idx   <= REG_SIG_TIMEOUT;
    cfg_wdata <= {noise[CfgDataW-1:AgeW], tmo};
    @(posedge clk);
    cfg_idx   <= REG_BATT_LOW;
    cfg_wdata <= {noise[CfgDataW-1:BattW], lo};
    @(posedge clk);
    cfg_idx   <= REG_BATT_CRITICAL;
    cfg_wdata <= {noise[CfgDataW-1:BattW], cr};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_regs();
    load_regs(temp_t'($urandom), BandW'($urandom_range(0, 255)),
              age_t'($urandom_range(0, 254)), batt_t'($urandom_range(0, 127)),
              batt_t'($urandom_range(0, 127)));
  endtask

  task automatic random_pass();
    int        r, spread, tv;
    cmd_code_t cmd;
    temp_t     t;
    r = $urandom_range(0, 99);
    if (r < 55) cmd = CMD_NONE;
    else if (r < 65) cmd = CMD_FORCE_ON;
    else if (r < 75) cmd = CMD_FORCE_OFF;
    else if (r < 85) cmd = CMD_PROG_ON;
    else if (r < 95) cmd = CMD_PROG_OFF;
    else cmd = cmd_code_t'($urandom_range(CmdSpareFirst, CmdSpareLast));
    if ($urandom_range(0, 9) == 0) mains_now = ~mains_now;
    if ($urandom_range(0, 3) != 0) begin
      spread = int'(band_now) + 8;
      tv = int'(sp_now) + int'($urandom_range(0, spread)) - spread / 2;
      t = tv[TempW-1:0];
    end else begin
      t = temp_t'($urandom);
    end
    send_pass(cmd, mains_now, $urandom_range(0, 2) == 0, $urandom_range(0, 5) == 0, t,
              batt_t'($urandom_range(0, 127)));
  endtask

  task automatic run_phase(int n);
    repeat (n) random_pass();
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= REG_SETPOINT;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= CMD_NONE;
    in_ch.mains_present  <= 1'b0;
    in_ch.minute_tick    <= 1'b0;
    in_ch.report_valid   <= 1'b0;
    in_ch.report_temp    <= '0;
    in_ch.report_battery <= '0;
    calm      = 1'b0;
    mains_now = 1'b0;
    hold_seq  = 0;
    sp_now    = SetpointReset;
    band_now  = HystReset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pass(CMD_NONE, 0, 0, 0, 0, 0);
    send_pass(CmdSpareFirst, 0, 0, 0, 0, 0);
    send_pass(cmd_code_t'(CmdSpareFirst + 1), 0, 0, 0, 0, 0);
    send_pass(CmdSpareLast, 0, 0, 0, 0, 0);
    send_pass(CMD_FORCE_ON, 0, 0, 0, 0, 0);
    send_pass(CMD_NONE, 1, 0, 0, 0, 0);
    send_pass(CMD_NONE, 1, 0, 0, 0, 0);
    send_pass(CMD_NONE, 0, 0, 0, 0, 0);
    send_pass(CMD_FORCE_OFF, 0, 0, 0, 0, 0);
    send_pass(CMD_PROG_ON, 0, 0, 0, 0, 0);
    send_pass(CMD_FORCE_ON, 0, 0, 0, 0, 0);
    send_pass(CMD_FORCE_OFF, 0, 0, 0, 0, 0);
    send_pass(CMD_NONE, 0, 0, 1, 280, 20);
    send_pass(CMD_NONE, 0, 0, 1, 296, 19);
    send_pass(CMD_NONE, 0, 0, 1, 312, 10);
    send_pass(CMD_NONE, 0, 0, 1, 313, 9);
    send_pass(CMD_NONE, 0, 0, 0, 0, 0);
    send_pass(CMD_PROG_OFF, 0, 0, 0, 0, 0);
    send_pass(CMD_NONE, 1, 1, 1, -2048, 127);
    send_pass(CMD_NONE, 0, 1, 1, 2047, 0);
    send_pass(CMD_PROG_ON, 0, 0, 1, -2048, 64);
    send_pass(CMD_NONE, 0, 0, 0, 0, 0);
    send_pass(CMD_NONE, 1, 0, 0, 0, 0);
    send_pass(CMD_NONE, 0, 0, 0, 0, 0);
    send_pass(CMD_NONE, 0, 0, 0, 0, 0);
    settle();

    load_regs(SetpointReset, HystReset, 2, BattLowReset, BattCritReset);
    send_pass(CMD_PROG_ON, 0, 0, 1, 100, 50);
    repeat (3) send_pass(CMD_NONE, 0, 1, 0, temp_t'($urandom), batt_t'($urandom));
    settle();

    load_regs(-2048, 0, 0, 0, 0);
    run_phase(PhaseLen);
    settle();
    load_regs(2047, 255, 254, 127, 127);
    run_phase(PhaseLen);
    settle();

    load_random_regs();
    hold_seq <= hold_seq + 1;
    calm = 1'b1;
    run_phase(30);
    calm = 1'b0;
    run_phase(PhaseLen - 30);
    settle();

    load_regs(SetpointReset, HystReset, 254, BattLowReset, BattCritReset);
    send_pass(CMD_PROG_ON, 0, 0, 1, SetpointReset, 50);
    repeat (SilenceLen)
      send_pass(CMD_NONE, 0, 1, 0, temp_t'($urandom), batt_t'($urandom));
    settle();

    for (int i = 0; i < 6; i++) begin
      load_random_regs();
      calm = (i == 2);
      run_phase(PhaseLen);
      settle();
    end
    calm = 1'b0;

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hrtc_pkg.sv
rtl/hrtc_ifs.sv
rtl/heating_relay_thermostat_controller.sv
rtl/hrtc_checker.sv
dv/hrtc_checker.sv
dv/tb_top.sv
